@@ hw/rtl/prd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_pkg: shared types for the point repulsor displacement block
// Transaction structs, the repulsor load bus and the token passed along the
// chain of repulsor cells.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int MAX_REPULSORS = 8;
    localparam int CELL_ID_W     = (MAX_REPULSORS > 1) ? $clog2(MAX_REPULSORS) : 1;
    localparam int CMP_W         = 8;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [2:0]         slot;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
        logic [30:0]        radius;
        logic signed [31:0] amount;
    } item_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               at_center;
    } result_t;

    typedef struct packed {
        logic        wr;
        logic [2:0]  slot;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] reach;
        logic [31:0] strength;
    } load_t;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic             flag;
    } tok_t;

    function automatic logic slot_hit(input logic [2:0] slot,
                                      input logic [CELL_ID_W-1:0] id);
        slot_hit = (CMP_W'(slot) == CMP_W'(id));
    endfunction

    function automatic logic cell_on(input logic [3:0] count,
                                     input logic [CELL_ID_W-1:0] id);
        cell_on = (CMP_W'(count) > CMP_W'(id));
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh07FFFFFFF;
        lo = -36'sh080000000;
        if (v > hi)
            sat32 = 32'h7FFFFFFF;
        else if (v < lo)
            sat32 = 32'h80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

@@ hw/rtl/point_repulsor_displacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_repulsor_displacement: spherical repulsor point displacement
// Loads repulsor slots and pushes Q16.16 points through a chain of cells.
// ----------------------------------------------------------------------------
// A load transaction writes one repulsor slot. A point transaction walks the
// chain of MAX_REPULSORS cells one at a time; one point is in flight. Each
// cell below active_count that acts on the point runs a 31-step square root,
// a 32-step fraction divide, a 64-step factor divide and nine push steps on
// the shared multiplier; a cell that skips the point (out of reach or at the
// centre) and an inactive cell pass it on without these steps. A finished
// point waits in the output register while the next transaction is taken.
module point_repulsor_displacement
    import prd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result
);

    logic [3:0] active_count_reg;
    logic       busy_reg;
    logic       result_valid_reg;
    result_t    result_reg;
    logic       item_acc;
    load_t      load;

    logic [MAX_REPULSORS:0] link_valid;
    logic [MAX_REPULSORS:0] link_ready;
    tok_t [MAX_REPULSORS:0] link_tok;

    assign cfg_ready  = 1'b1;
    assign item_ready = !busy_reg;
    assign item_acc   = item_valid && item_ready;

    assign load.wr       = item_acc && (item.kind == KIND_LOAD);
    assign load.slot     = item.slot;
    assign load.cx       = item.x_in;
    assign load.cy       = item.y_in;
    assign load.cz       = item.z_in;
    assign load.reach    = item.radius;
    assign load.strength = item.amount;

    assign link_valid[0]  = item_acc && (item.kind == KIND_POINT);
    assign link_tok[0].p  = {item.z_in, item.y_in, item.x_in};
    assign link_tok[0].flag = 1'b0;
    assign link_ready[MAX_REPULSORS] = !result_valid_reg || result_ready;

    for (genvar i = 0; i < MAX_REPULSORS; i++)
    begin : g_cell
        prd_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_id      (CELL_ID_W'(i)),
            .active_count (active_count_reg),
            .load         (load),
            .prev_valid   (link_valid[i]),
            .prev_ready   (link_ready[i]),
            .prev_tok     (link_tok[i]),
            .next_valid   (link_valid[i+1]),
            .next_ready   (link_ready[i+1]),
            .next_tok     (link_tok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= 4'd0;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_count_reg <= cfg_data;
            if (link_valid[0])
                busy_reg <= 1'b1;
            else if (link_valid[MAX_REPULSORS] && link_ready[MAX_REPULSORS])
                busy_reg <= 1'b0;
            if (link_valid[MAX_REPULSORS] && link_ready[MAX_REPULSORS])
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_valid[MAX_REPULSORS] && link_ready[MAX_REPULSORS])
        begin
            result_reg.x_out     <= link_tok[MAX_REPULSORS].p[0];
            result_reg.y_out     <= link_tok[MAX_REPULSORS].p[1];
            result_reg.z_out     <= link_tok[MAX_REPULSORS].p[2];
            result_reg.at_center <= link_tok[MAX_REPULSORS].flag;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_chain_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[MAX_REPULSORS] |-> busy_reg)
        else $error("chain output without a point in flight");

    a_busy_from_point: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(item_valid && item_ready && item.kind == KIND_POINT))
        else $error("busy set without a point transaction");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[MAX_REPULSORS] && !link_ready[MAX_REPULSORS]
            |=> link_valid[MAX_REPULSORS])
        else $error("finished point dropped at chain end");
`endif

endmodule

@@ hw/rtl/prd_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_cell: one repulsor slot of the displacement chain
// Holds one repulsor and applies it to the point token with an iterative
// square root, two restoring dividers and a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module prd_cell
    import prd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CELL_ID_W-1:0] cell_id,
    input  logic [3:0]           active_count,
    input  load_t                load,
    input  logic                 prev_valid,
    output logic                 prev_ready,
    input  tok_t                 prev_tok,
    output logic                 next_valid,
    input  logic                 next_ready,
    output tok_t                 next_tok
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_OFFS = 11'b00000000010,
        S_SQR  = 11'b00000000100,
        S_CHK  = 11'b00000001000,
        S_ROOT = 11'b00000010000,
        S_QDIV = 11'b00000100000,
        S_MULM = 11'b00001000000,
        S_MULF = 11'b00010000000,
        S_FDIV = 11'b00100000000,
        S_PUSH = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic [1:0]  phase_reg, phase_next;

    logic [31:0] cx_reg, cy_reg, cz_reg, strength_reg;
    logic [30:0] reach_reg;

    logic [2:0][31:0] p_reg, p_next;
    logic             flag_reg, flag_next;
    logic [2:0]       osign_reg, osign_next;
    logic [2:0][30:0] om_reg, om_next;
    logic             far_reg, far_next;
    logic [63:0]      acc_reg, acc_next;
    logic [61:0]      rad_reg, rad_next;
    logic [30:0]      root_reg, root_next;
    logic [33:0]      rem_reg, rem_next;
    logic [31:0]      q_reg, q_next;
    logic [63:0]      num_reg, num_next;
    logic [61:0]      lo_reg, lo_next;
    logic [63:0]      mul_reg, mul_next;

    logic [31:0] mul_a, mul_b;
    logic [31:0] a_mag;
    logic [2:0][31:0] cen;
    logic [2:0][32:0] o_full;
    logic [2:0][32:0] o_mag;
    logic [2:0]       o_far;
    logic [35:0] rt_tmp, rt_trial;
    logic        rt_ge;
    logic [31:0] qd_t;
    logic        qd_ge;
    logic [63:0] fd_src;
    logic [31:0] fd_t;
    logic        fd_ge;
    logic [92:0] pu_total;
    logic [76:0] pu_wide;
    logic [33:0] pu_dm;
    logic signed [35:0] pu_p, pu_sum;

    assign a_mag = strength_reg[31] ? (~strength_reg + 32'd1) : strength_reg;
    assign cen   = {cz_reg, cy_reg, cx_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            o_full[k] = {p_reg[k][31], p_reg[k]} - {cen[k][31], cen[k]};
            o_mag[k]  = o_full[k][32] ? (~o_full[k] + 33'd1) : o_full[k];
            o_far[k]  = o_mag[k] > {2'b00, reach_reg};
        end
    end

    assign rt_tmp   = {rem_reg, rad_reg[61:60]};
    assign rt_trial = {3'b000, root_reg, 2'b01};
    assign rt_ge    = rt_tmp >= rt_trial;

    assign qd_t  = {rem_reg[30:0], 1'b0};
    assign qd_ge = qd_t >= {1'b0, reach_reg};

    assign fd_src = (cnt_reg == 7'd0) ? mul_reg : num_reg;
    assign fd_t   = {rem_reg[30:0], fd_src[63]};
    assign fd_ge  = fd_t >= {1'b0, root_reg};

    assign pu_total = {mul_reg[61:0], 31'd0} + {31'd0, lo_reg};
    assign pu_wide  = pu_total[92:16];
    assign pu_dm    = ((|pu_wide[76:34]) || (pu_wide[33] && (|pu_wide[32:0])))
                      ? 34'h200000000 : pu_wide[33:0];
    assign pu_p     = {{4{p_reg[comp_reg][31]}}, p_reg[comp_reg]};
    assign pu_sum   = osign_reg[comp_reg] ? (pu_p - $signed({2'b00, pu_dm}))
                                          : (pu_p + $signed({2'b00, pu_dm}));

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_SQR:
            begin
                if (cnt_reg == 7'd3)
                begin
                    mul_a = {1'b0, reach_reg};
                    mul_b = {1'b0, reach_reg};
                end
                else
                begin
                    mul_a = {1'b0, om_reg[cnt_reg[1:0]]};
                    mul_b = {1'b0, om_reg[cnt_reg[1:0]]};
                end
            end
            S_MULM:
            begin
                mul_a = a_mag;
                mul_b = q_reg;
            end
            S_MULF:
            begin
                mul_a = a_mag;
                mul_b = mul_reg[63:32];
            end
            S_PUSH:
            begin
                mul_a = {1'b0, om_reg[comp_reg]};
                mul_b = (phase_reg == 2'd0) ? {1'b0, num_reg[30:0]}
                                            : {1'b0, num_reg[61:31]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_next = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        phase_next = phase_reg;
        p_next     = p_reg;
        flag_next  = flag_reg;
        osign_next = osign_reg;
        om_next    = om_reg;
        far_next   = far_reg;
        acc_next   = acc_reg;
        rad_next   = rad_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        num_next   = num_reg;
        lo_next    = lo_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (prev_valid)
                begin
                    p_next     = prev_tok.p;
                    flag_next  = prev_tok.flag;
                    state_next = cell_on(active_count, cell_id) ? S_OFFS : S_DONE;
                end
            end
            S_OFFS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    osign_next[k] = o_full[k][32];
                    om_next[k]    = o_mag[k][30:0];
                end
                far_next   = |o_far;
                acc_next   = 64'd0;
                cnt_next   = 7'd0;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                if (cnt_reg != 7'd0)
                    acc_next = acc_reg + mul_reg;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd3)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (far_reg || (acc_reg > mul_reg))
                    state_next = S_DONE;
                else if (acc_reg == 64'd0)
                begin
                    flag_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rad_next   = acc_reg[61:0];
                    rem_next   = 34'd0;
                    root_next  = 31'd0;
                    cnt_next   = 7'd0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                rem_next  = rt_ge ? 34'(rt_tmp - rt_trial) : rt_tmp[33:0];
                root_next = {root_reg[29:0], rt_ge};
                rad_next  = {rad_reg[59:0], 2'b00};
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd30)
                begin
                    rem_next   = {3'b000, reach_reg - {root_reg[29:0], rt_ge}};
                    q_next     = 32'd0;
                    cnt_next   = 7'd0;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                rem_next = qd_ge ? {2'b00, qd_t - {1'b0, reach_reg}} : {2'b00, qd_t};
                q_next   = {q_reg[30:0], qd_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd31)
                    state_next = S_MULM;
            end
            S_MULM:
            begin
                state_next = S_MULF;
            end
            S_MULF:
            begin
                rem_next   = 34'd0;
                cnt_next   = 7'd0;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                rem_next = fd_ge ? {2'b00, fd_t - {1'b0, root_reg}} : {2'b00, fd_t};
                num_next = {fd_src[62:0], fd_ge};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    comp_next  = 2'd0;
                    phase_next = 2'd0;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                case (phase_reg)
                    2'd0:
                        phase_next = 2'd1;
                    2'd1:
                    begin
                        lo_next    = mul_reg[61:0];
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        p_next[comp_reg] = sat32(pu_sum);
                        phase_next       = 2'd0;
                        comp_next        = comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                            state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (next_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign prev_ready    = (state_reg == S_IDLE);
    assign next_valid    = (state_reg == S_DONE);
    assign next_tok.p    = p_reg;
    assign next_tok.flag = flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 7'd0;
            comp_reg  <= 2'd0;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.wr && slot_hit(load.slot, cell_id))
        begin
            cx_reg       <= load.cx;
            cy_reg       <= load.cy;
            cz_reg       <= load.cz;
            reach_reg    <= load.reach;
            strength_reg <= load.strength;
        end
        p_reg     <= p_next;
        flag_reg  <= flag_next;
        osign_reg <= osign_next;
        om_reg    <= om_next;
        far_reg   <= far_next;
        acc_reg   <= acc_next;
        rad_reg   <= rad_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        num_reg   <= num_next;
        lo_reg    <= lo_next;
        mul_reg   <= mul_next;
    end

`ifndef SYNTH
    a_idle_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        prev_ready |-> !next_valid)
        else $error("cell idle and done at once");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDIV) |-> (root_reg != 31'd0 && root_reg <= reach_reg))
        else $error("distance outside one to radius");

    a_qdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDIV) |-> (rem_reg < {3'b000, reach_reg}))
        else $error("fraction remainder not below radius");

    a_factor_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |-> (num_reg[63:62] == 2'b00))
        else $error("factor exceeds 62 bits");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for point_repulsor_displacement
// Loads repulsor slots, streams Q16.16 points through the block and compares
// each displaced point against a bit-accurate model of the repulsor chain.
// Both handshakes idle at random; the active count is changed between phases.
// ----------------------------------------------------------------------------
module tb;
    import prd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [3:0] cfg_data;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    logic [31:0] ctr_x [MAX_REPULSORS];
    logic [31:0] ctr_y [MAX_REPULSORS];
    logic [31:0] ctr_z [MAX_REPULSORS];
    logic [30:0] reach_tab [MAX_REPULSORS];
    logic [31:0] strength_tab [MAX_REPULSORS];
    bit          loaded [MAX_REPULSORS];
    logic [3:0]  active_n;

    result_t expected_points [$];
    int      errors;
    int      idle_cycles;
    bit      hold_off;
    bit      long_gaps;

    point_repulsor_displacement dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        mag = (v < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        isqrt = res;
    endfunction

    function automatic logic signed [63:0] push_coord(input logic signed [63:0] p,
                                                     input logic signed [63:0] o,
                                                     input logic [63:0] f);
        logic [63:0]  om;
        logic [127:0] prod;
        logic [127:0] dm;
        logic signed [63:0] r;
        om = mag(o);
        prod = {64'd0, om} * {64'd0, f};
        dm = prod >> 16;
        if (prod[127:64] != 0 || dm > (128'd1 << 33))
            dm = 128'd1 << 33;
        r = (o < 0) ? p - $signed(dm[63:0]) : p + $signed(dm[63:0]);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        else if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        push_coord = r;
    endfunction

    function automatic result_t displace_point(input item_t it);
        logic signed [63:0] p [3];
        logic signed [63:0] o [3];
        logic [63:0] r, a, s, d, q, m, f, om;
        logic [127:0] wide;
        int n;
        bit far;
        result_t res;
        p[0] = it.x_in;
        p[1] = it.y_in;
        p[2] = it.z_in;
        res.at_center = 1'b0;
        n = (active_n > MAX_REPULSORS) ? MAX_REPULSORS : active_n;
        for (int i = 0; i < n; i++)
        begin
            r = reach_tab[i];
            a = mag($signed(strength_tab[i]));
            o[0] = p[0] - $signed(ctr_x[i]);
            o[1] = p[1] - $signed(ctr_y[i]);
            o[2] = p[2] - $signed(ctr_z[i]);
            s = 0;
            far = 0;
            for (int k = 0; k < 3; k++)
            begin
                om = mag(o[k]);
                if (om > r)
                    far = 1;
                else
                    s = s + om * om;
            end
            if (far || s > r * r)
                continue;
            if (s == 0)
            begin
                res.at_center = 1'b1;
                continue;
            end
            d = isqrt(s);
            wide = {64'd0, r - d} << 32;
            q = wide / r;
            wide = {64'd0, a} * {64'd0, q};
            m = wide >> 32;
            f = (a * m) / d;
            for (int k = 0; k < 3; k++)
                p[k] = push_coord(p[k], o[k], f);
        end
        res.x_out = p[0][31:0];
        res.y_out = p[1][31:0];
        res.z_out = p[2][31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("unexpected result at %0t", $time);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_points.pop_front();
                if (result.x_out !== e.x_out)
                    report_mismatch("x_out", result.x_out, e.x_out);
                if (result.y_out !== e.y_out)
                    report_mismatch("y_out", result.y_out, e.y_out);
                if (result.z_out !== e.z_out)
                    report_mismatch("z_out", result.z_out, e.z_out);
                if (result.at_center !== e.at_center)
                    report_mismatch("at_center", result.at_center, e.at_center);
            end
        end
    end

    // randomize result_ready, honoring a long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (hold_off)
            result_ready <= 1'b0;
        else if (long_gaps)
            result_ready <= ($urandom_range(0, 9) != 0) ? ($urandom_range(0, 3) == 0)
                                                        : 1'b1;
        else
            result_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic gap(input bit none);
        int n;
        if (none)
            return;
        if ($urandom_range(0, 19) == 0)
            n = $urandom_range(10, 60);
        else if ($urandom_range(0, 2) == 0)
            n = $urandom_range(1, 3);
        else
            n = 0;
        if (n > 0)
            item_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input item_t it, input bit no_gap = 0);
        gap(no_gap);
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (it.kind == KIND_LOAD)
        begin
            if (it.slot < MAX_REPULSORS)
            begin
                ctr_x[it.slot] = it.x_in;
                ctr_y[it.slot] = it.y_in;
                ctr_z[it.slot] = it.z_in;
                reach_tab[it.slot] = it.radius;
                strength_tab[it.slot] = it.amount;
                loaded[it.slot] = 1;
            end
        end
        else
            expected_points.push_back(displace_point(it));
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_count(input logic [3:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        active_n = n;
    endtask

    function automatic item_t load_item(input logic [2:0] slot, input logic [31:0] cx,
                                        input logic [31:0] cy, input logic [31:0] cz,
                                        input logic [30:0] rad, input logic [31:0] amt);
        item_t it;
        it.kind = KIND_LOAD;
        it.slot = slot;
        it.x_in = cx;
        it.y_in = cy;
        it.z_in = cz;
        it.radius = rad;
        it.amount = amt;
        return it;
    endfunction

    function automatic item_t point_item(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
        item_t it;
        it = load_item(3'($urandom), x, y, z, 31'($urandom), $urandom);
        it.kind = KIND_POINT;
        return it;
    endfunction

    function automatic logic [31:0] near(input logic [31:0] c, input logic [30:0] rad);
        logic signed [63:0] off;
        off = $signed({1'b0, $urandom}) % (64'sd1 + rad);
        if ($urandom_range(0, 1))
            off = -off;
        off = off + $signed(c);
        if ($urandom_range(0, 7) == 0)
            off = off + $signed({1'b0, $urandom_range(0, 65535)});
        if (off > 64'sd2147483647)
            off = 64'sd2147483647;
        if (off < -64'sd2147483648)
            off = -64'sd2147483648;
        return off[31:0];
    endfunction

    function automatic logic [30:0] rand_radius;
        case ($urandom_range(0, 5))
            0: return 31'd0;
            1: return 31'($urandom_range(1, 32'h0000FFFF));
            2: return 31'h7FFFFFFF;
            3: return 31'($urandom);
            default: return 31'($urandom_range(32'h00010000, 32'h00400000));
        endcase
    endfunction

    function automatic item_t rand_load(input logic [2:0] slot);
        logic [31:0] amt;
        amt = $urandom_range(0, 3) == 0 ? $urandom
                                        : $urandom_range(0, 32'h00040000);
        if ($urandom_range(0, 1))
            amt = -amt;
        return load_item(slot, $urandom_range(0, 1) ? $urandom
                                                    : $urandom_range(0, 32'h00100000),
                         $urandom, $urandom_range(0, 3) == 0 ? $urandom : 32'h0,
                         rand_radius(), amt);
    endfunction

    function automatic item_t rand_point;
        int s;
        s = $urandom_range(0, 7);
        if (!loaded[s] || $urandom_range(0, 4) == 0)
            return point_item($urandom, $urandom, $urandom);
        if ($urandom_range(0, 15) == 0)
            return point_item(ctr_x[s], ctr_y[s], ctr_z[s]);
        return point_item(near(ctr_x[s], reach_tab[s]), near(ctr_y[s], reach_tab[s]),
                          near(ctr_z[s], reach_tab[s]));
    endfunction

    task automatic test_directed;
        send_item(load_item(3'd0, 32'h00010000, 32'h0, 32'h0, 31'h00020000,
                            32'h00010000));
        send_item(load_item(3'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                            32'h80000000));
        send_item(load_item(3'd2, 32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                            32'h7FFFFFFF));
        send_item(load_item(3'd3, 32'h0, 32'h0, 32'h0, 31'd0, 32'hFFFF0000));
        send_item(load_item(3'd4, 32'hFFFF0000, 32'h00008000, 32'h0, 31'h00010000,
                            32'h00100000));
        send_item(load_item(3'd5, 32'h0, 32'h0, 32'h0, 31'h7FFFFFFF, 32'h7FFFFFFF));
        send_item(load_item(3'd6, 32'h00050000, 32'hFFFB0000, 32'h0, 31'h00001000,
                            32'h00000100));
        send_item(load_item(3'd7, 32'h0, 32'h0, 32'h00030000, 31'h00100000, 32'h0));
        write_count(4'd1);
        send_item(point_item(32'h00018000, 32'h0, 32'h0));
        send_item(point_item(32'h00010000, 32'h0, 32'h0));
        send_item(point_item(32'h00040000, 32'h0, 32'h0));
        write_count(4'd8);
        send_item(point_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_item(point_item(32'h80000000, 32'h80000000, 32'h80000000));
        send_item(point_item(32'h0, 32'h0, 32'h0));
        send_item(point_item(32'h00000001, 32'hFFFFFFFF, 32'h0));
        write_count(4'd15);
        send_item(load_item(3'd7, 32'h0, 32'h0, 32'h0, 31'h00010000, 32'h00010000));
        send_item(point_item(32'h0, 32'h00008000, 32'h00000100));
        send_item(point_item(32'h00050400, 32'hFFFB0000, 32'h0));
        write_count(4'd0);
        send_item(point_item(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(rand_load(3'($urandom_range(0, 7))));
            else
                send_item(rand_point());
        end
    endtask

    task automatic test_back_pressure;
        hold_off = 1;
        fork
            begin
                repeat (6000) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_item(rand_point(), 1);
        join
        drain();
        for (int i = 0; i < 10; i++)
            send_item(rand_point(), 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        item_valid = 1'b0;
        item = '0;
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        long_gaps = 0;
        active_n = 4'd0;
        for (int i = 0; i < MAX_REPULSORS; i++)
            loaded[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_count(4'd3);
        test_random(500);
        long_gaps = 1;
        write_count(4'd8);
        test_random(500);
        test_back_pressure();
        long_gaps = 0;
        write_count(4'd2);
        test_random(400);
        write_count(4'd9);
        test_random(380);
        drain();
        if (errors == 0 && expected_points.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/prd_pkg.sv
hw/rtl/prd_cell.sv
hw/rtl/point_repulsor_displacement.sv
tb/tb.sv
